// ===== rtl/assert_macros.svh =====
// Assertion macros used by the voice allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/vla_pkg.sv =====
// Shared types, codes and constants of the voice allocator.
`timescale 1ns / 1ps

package vla_pkg;

    localparam int MAX_VOICES_DEF = 16;

    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 16;
    localparam int VC_W       = 5;
    localparam int VOICE_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STOPPED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLAYING  = 2'd2;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_BUFFER  = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;
    localparam logic [1:0] ACT_HALT    = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_NO_PENDING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_LIMIT = 4'd1;

    localparam logic [VC_W-1:0]  VC_RESET = 5'd16;
    localparam logic [CNT_W-1:0] DL_RESET = 16'd15;
    localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

    // One result item; status sits in the lowest bits.
    typedef struct packed {
        logic                started;
        logic                release_stream;
        logic [1:0]          action;
        logic [VOICE_W-1:0]  voice;
        logic [1:0]          status;
    } res_t;

    typedef struct packed {
        logic latch_in;
        logic quick_res;
        logic scan_init;
        logic scan_step;
        logic alloc_commit;
        logic start_rd;
        logic start_exec;
        logic ev_rd;
        logic ev_exec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            present;
        logic            pend_vld;
        logic            ev_oob;
        logic            scan_done;
        logic            out_free;
    } sts_t;

endpackage

// ===== rtl/voice_allocator_lru_steal.sv =====
// Top level of the voice allocator with recency ordering and voice stealing.
//
//   channel  direction  handshake             payload
//   s_       in         s_tvalid / s_tready   s_tdata, s_tuser (request)
//   m_       out        m_tvalid / m_tready   m_tdata (result)
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// An allocate that searches passes through the decode, scan, commit and output
// states; the search checks one list position per cycle through the single read
// port of the voice memory. Start and buffer-done pass through decode, an execute
// state and output; requests answered without a memory access go from decode to output.
// Reset is synchronous and active low; it restores the identity recency order,
// all voices stopped and all enqueue counts at zero without a clearing pass.
// A stalled result is held in the output register while the next request is taken.
`timescale 1ns / 1ps

module voice_allocator_lru_steal #(
    parameter int MAX_VOICES = vla_pkg::MAX_VOICES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: sound_present, event_voice[3:0], has_samples, zero pad.
    input  logic [vla_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [vla_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: status[1:0], voice[3:0], action[1:0], release_stream,
    // started, zero pad.
    output logic [vla_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vla_pkg::CFG_DATA_W-1:0]    cfg_data
);

    vla_pkg::cmd_t cmd;
    vla_pkg::sts_t sts;

    vla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vla_dp #(
        .MAX_VOICES (MAX_VOICES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/vla_ctrl.sv =====
// Sequencing state machine of the voice allocator.
`timescale 1ns / 1ps

module vla_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  vla_pkg::sts_t sts,
    output vla_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_COMMIT = 7'b0001000,
        S_ST_EXE = 7'b0010000,
        S_EV_EXE = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.op)
                    vla_pkg::OP_ALLOC: begin
                        if (!sts.present || sts.pend_vld) begin
                            cmd.quick_res = 1'b1;
                            state_next    = S_OUT;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    vla_pkg::OP_START: begin
                        if (!sts.pend_vld) begin
                            cmd.quick_res = 1'b1;
                            state_next    = S_OUT;
                        end else begin
                            cmd.start_rd = 1'b1;
                            state_next   = S_ST_EXE;
                        end
                    end
                    vla_pkg::OP_EVENT: begin
                        if (sts.ev_oob) begin
                            cmd.quick_res = 1'b1;
                            state_next    = S_OUT;
                        end else begin
                            cmd.ev_rd  = 1'b1;
                            state_next = S_EV_EXE;
                        end
                    end
                    default: begin
                        cmd.quick_res = 1'b1;
                        state_next    = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_OUT;
            end
            S_ST_EXE: begin
                cmd.start_exec = 1'b1;
                state_next     = S_OUT;
            end
            S_EV_EXE: begin
                cmd.ev_exec = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                // Wait here until the output register can take the result.
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/vla_dp.sv =====
// Datapath of the voice allocator: recency list, voice memory, pending voice and result.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module vla_dp #(
    parameter int MAX_VOICES = vla_pkg::MAX_VOICES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vla_pkg::cmd_t                     cmd,
    output vla_pkg::sts_t                     sts,
    input  logic [vla_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [vla_pkg::OP_W-1:0]          s_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vla_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vla_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW = vla_pkg::CNT_W;
    localparam int MW = vla_pkg::MODE_W;
    localparam int WW = CW + MW;
    localparam int PADW = vla_pkg::OUT_TDATA_W - $bits(vla_pkg::res_t);

    // Configuration registers; writes to unknown indexes are dropped.
    logic [vla_pkg::VC_W-1:0] vc_reg;
    logic [CW-1:0]            dl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= vla_pkg::VC_RESET;
            dl_reg <= vla_pkg::DL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == vla_pkg::CFG_VOICE_COUNT) begin
                vc_reg <= cfg_data[vla_pkg::VC_W-1:0];
            end else if (cfg_index == vla_pkg::CFG_DRAIN_LIMIT) begin
                dl_reg <= cfg_data;
            end
        end
    end

    // Oldest position of the list in use, after clamping the voice count.
    logic [VW-1:0] last_pos;

    always_comb begin
        if (vc_reg == '0) begin
            last_pos = '0;
        end else if (32'(vc_reg) > MAX_VOICES) begin
            last_pos = VW'(MAX_VOICES - 1);
        end else begin
            last_pos = VW'(vc_reg - 5'd1);
        end
    end

    // Latched input transaction.
    logic [vla_pkg::OP_W-1:0]    op_reg;
    logic                        present_reg;
    logic [vla_pkg::VOICE_W-1:0] evv_reg;
    logic                        samples_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg      <= s_tuser;
            present_reg <= s_tdata[0];
            evv_reg     <= s_tdata[4:1];
            samples_reg <= s_tdata[5];
        end
    end

    logic [VW-1:0] ev_addr;
    logic          ev_oob;

    assign ev_addr = VW'(evv_reg);
    assign ev_oob  = (32'(evv_reg) >= MAX_VOICES);

    // Recency list, most recent at position 0.
    logic [VW-1:0] rec_reg  [MAX_VOICES];
    logic [VW-1:0] rec_next [MAX_VOICES];

    // Pending voice.
    logic          pend_vld_reg, pend_vld_next;
    logic [VW-1:0] pend_voice_reg, pend_voice_next;

    // Voice memory: {enqueue count, mode}, with one valid bit per voice for reset.
    logic [WW-1:0]         mem [MAX_VOICES];
    logic [MAX_VOICES-1:0] vld_reg;
    logic [WW-1:0]         rdata_reg;
    logic                  rvld_reg;
    logic [VW-1:0]         rd_addr;
    logic                  wr_en;
    logic [VW-1:0]         wr_addr;
    logic [WW-1:0]         wr_word;
    logic [WW-1:0]         word_rd;
    logic [MW-1:0]         mode_rd;
    logic [CW-1:0]         cnt_rd;
    logic [CW-1:0]         cnt_inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            rvld_reg <= vld_reg[rd_addr];
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign word_rd = rvld_reg ? rdata_reg : '0;
    assign mode_rd = word_rd[MW-1:0];
    assign cnt_rd  = word_rd[WW-1:MW];
    assign cnt_inc = (cnt_rd == vla_pkg::CNT_MAX) ? cnt_rd : cnt_rd + CW'(1);

    // Scan pipeline: a position is issued one cycle, its voice word checked the next.
    logic          issue_on_reg, issue_on_next;
    logic [VW-1:0] scan_pos_reg, scan_pos_next;
    logic          evon_reg, evon_next;
    logic [VW-1:0] evp_reg, evp_next;
    logic [VW-1:0] evvo_reg, evvo_next;
    logic          hit_reg, hit_next;
    logic [VW-1:0] hit_pos_reg, hit_pos_next;
    logic [VW-1:0] hit_voice_reg, hit_voice_next;
    logic          stp_found_reg, stp_found_next;
    logic [VW-1:0] stp_pos_reg, stp_pos_next;
    logic [VW-1:0] stp_voice_reg, stp_voice_next;
    logic [CW-1:0] stp_cnt_reg, stp_cnt_next;
    logic [VW-1:0] old_voice_reg, old_voice_next;
    logic [CW-1:0] old_cnt_reg, old_cnt_next;

    logic          is_stopped;
    logic          is_stopping;

    assign is_stopped  = (mode_rd == vla_pkg::MODE_STOPPED);
    assign is_stopping = (mode_rd == vla_pkg::MODE_STOPPING);

    always_comb begin
        issue_on_next  = issue_on_reg;
        scan_pos_next  = scan_pos_reg;
        evon_next      = 1'b0;
        evp_next       = evp_reg;
        evvo_next      = evvo_reg;
        hit_next       = hit_reg;
        hit_pos_next   = hit_pos_reg;
        hit_voice_next = hit_voice_reg;
        stp_found_next = stp_found_reg;
        stp_pos_next   = stp_pos_reg;
        stp_voice_next = stp_voice_reg;
        stp_cnt_next   = stp_cnt_reg;
        old_voice_next = old_voice_reg;
        old_cnt_next   = old_cnt_reg;
        if (cmd.scan_init) begin
            issue_on_next  = 1'b1;
            scan_pos_next  = last_pos;
            hit_next       = 1'b0;
            stp_found_next = 1'b0;
        end
        if (cmd.scan_step) begin
            if (issue_on_reg) begin
                evon_next = 1'b1;
                evp_next  = scan_pos_reg;
                evvo_next = rec_reg[scan_pos_reg];
                if (scan_pos_reg == '0) begin
                    issue_on_next = 1'b0;
                end else begin
                    scan_pos_next = scan_pos_reg - VW'(1);
                end
            end
            if (evon_reg) begin
                if (evp_reg == last_pos) begin
                    old_voice_next = evvo_reg;
                    old_cnt_next   = cnt_rd;
                end
                if (is_stopped && !hit_reg) begin
                    hit_next       = 1'b1;
                    hit_pos_next   = evp_reg;
                    hit_voice_next = evvo_reg;
                end else if (is_stopping && !stp_found_reg) begin
                    stp_found_next = 1'b1;
                    stp_pos_next   = evp_reg;
                    stp_voice_next = evvo_reg;
                    stp_cnt_next   = cnt_rd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_on_reg  <= 1'b0;
            evon_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            stp_found_reg <= 1'b0;
        end else begin
            issue_on_reg  <= issue_on_next;
            evon_reg      <= evon_next;
            hit_reg       <= hit_next;
            stp_found_reg <= stp_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_pos_reg  <= scan_pos_next;
        evp_reg       <= evp_next;
        evvo_reg      <= evvo_next;
        hit_pos_reg   <= hit_pos_next;
        hit_voice_reg <= hit_voice_next;
        stp_pos_reg   <= stp_pos_next;
        stp_voice_reg <= stp_voice_next;
        stp_cnt_reg   <= stp_cnt_next;
        old_voice_reg <= old_voice_next;
        old_cnt_reg   <= old_cnt_next;
    end

    // Choice at commit: a stopped voice, else the oldest stopping one, else the oldest.
    logic          stolen;
    logic [VW-1:0] ch_pos;
    logic [VW-1:0] ch_voice;
    logic [CW-1:0] ch_cnt;

    always_comb begin
        stolen = !hit_reg;
        if (hit_reg) begin
            ch_pos   = hit_pos_reg;
            ch_voice = hit_voice_reg;
        end else if (stp_found_reg) begin
            ch_pos   = stp_pos_reg;
            ch_voice = stp_voice_reg;
        end else begin
            ch_pos   = last_pos;
            ch_voice = old_voice_reg;
        end
        ch_cnt = stp_found_reg ? stp_cnt_reg : old_cnt_reg;
    end

    always_comb begin
        rec_next[0] = rec_reg[0];
        if (cmd.alloc_commit) begin
            rec_next[0] = ch_voice;
        end
        for (int i = 1; i < MAX_VOICES; i++) begin
            rec_next[i] = rec_reg[i];
            if (cmd.alloc_commit && (VW'(i) <= ch_pos)) begin
                rec_next[i] = rec_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                rec_reg[i] <= VW'(i);
            end
        end else begin
            rec_reg <= rec_next;
        end
    end

    // Memory read address.
    always_comb begin
        priority if (cmd.scan_step) begin
            rd_addr = rec_reg[scan_pos_reg];
        end else if (cmd.start_rd) begin
            rd_addr = pend_voice_reg;
        end else begin
            rd_addr = ev_addr;
        end
    end

    // Memory writes, pending voice and the staged result.
    vla_pkg::res_t res_reg, res_next;

    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = ev_addr;
        wr_word         = {cnt_rd, mode_rd};
        pend_vld_next   = pend_vld_reg;
        pend_voice_next = pend_voice_reg;
        res_next        = res_reg;
        if (cmd.quick_res) begin
            res_next = '0;
            unique case (op_reg)
                vla_pkg::OP_ALLOC: begin
                    if (!present_reg) begin
                        res_next.status = vla_pkg::ST_NOT_LOADED;
                    end else begin
                        res_next.voice = 4'(pend_voice_reg);
                    end
                end
                vla_pkg::OP_START: begin
                    res_next.status = vla_pkg::ST_NO_PENDING;
                end
                vla_pkg::OP_EVENT: begin
                    res_next.voice = evv_reg;
                end
                default: begin
                    res_next = '0;
                end
            endcase
        end
        if (cmd.alloc_commit) begin
            wr_en           = stolen;
            wr_addr         = ch_voice;
            wr_word         = {ch_cnt, vla_pkg::MODE_STOPPED};
            pend_vld_next   = 1'b1;
            pend_voice_next = ch_voice;
            res_next        = '0;
            res_next.voice  = 4'(ch_voice);
            res_next.release_stream = stolen;
        end
        if (cmd.start_exec) begin
            pend_vld_next  = 1'b0;
            res_next       = '0;
            res_next.voice = 4'(pend_voice_reg);
            wr_addr        = pend_voice_reg;
            if (is_stopped) begin
                wr_en            = 1'b1;
                wr_word          = {{CW{1'b0}}, vla_pkg::MODE_PLAYING};
                res_next.action  = vla_pkg::ACT_BUFFER;
                res_next.started = 1'b1;
            end
        end
        if (cmd.ev_exec) begin
            wr_en          = 1'b1;
            wr_addr        = ev_addr;
            res_next       = '0;
            res_next.voice = evv_reg;
            if (is_stopping) begin
                if (cnt_rd > dl_reg) begin
                    wr_word         = {cnt_rd, vla_pkg::MODE_STOPPED};
                    res_next.action = vla_pkg::ACT_HALT;
                end else begin
                    wr_word         = {cnt_inc, vla_pkg::MODE_STOPPING};
                    res_next.action = vla_pkg::ACT_SILENCE;
                end
            end else if (samples_reg) begin
                wr_word         = {cnt_inc, mode_rd};
                res_next.action = vla_pkg::ACT_BUFFER;
            end else begin
                wr_word                 = {cnt_rd, vla_pkg::MODE_STOPPING};
                res_next.action         = vla_pkg::ACT_SILENCE;
                res_next.release_stream = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg   <= 1'b0;
            pend_voice_reg <= '0;
        end else begin
            pend_vld_reg   <= pend_vld_next;
            pend_voice_reg <= pend_voice_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Output register; a finished result waits here while the next transaction is taken.
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [vla_pkg::OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                              out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PADW{1'b0}}, res_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts.op        = op_reg;
        sts.present   = present_reg;
        sts.pend_vld  = pend_vld_reg;
        sts.ev_oob    = ev_oob;
        sts.scan_done = evon_reg && (is_stopped || (evp_reg == '0));
        sts.out_free  = out_free;
    end

    `ASSERT_NXT(a_pend_front, cmd.alloc_commit, pend_vld_reg && (pend_voice_reg == rec_reg[0]))
    `ASSERT_IMP(a_load_free, cmd.load_out, !m_tvalid_reg || m_tready)
    `ASSERT_IMP(a_one_writer, 1'b1, $onehot0({cmd.alloc_commit, cmd.start_exec, cmd.ev_exec}))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the voice allocator: directed table, random phases, gapless stretch.
`timescale 1ns / 1ps

module tb;
    import vla_pkg::*;

    localparam int NV = MAX_VOICES_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;
    localparam int IDLE_PCT = 32;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 900;
    localparam int GAPLESS_ITEMS = 200;
    localparam int MAX_PRINTS = 100;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [OP_W-1:0] op;
        logic present;
        logic [VOICE_W-1:0] ev;
        logic samples;
        logic typed;
        res_t want;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } row_t;

    // Expectation attached to a request before it is offered.
    typedef struct packed {
        logic typed;
        res_t want;
    } note_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted allocator state.
    logic [VOICE_W-1:0] lru [NV];
    logic [MODE_W-1:0] vmode [NV];
    logic [CNT_W-1:0] enq_cnt [NV];
    logic pend_vld;
    logic [VOICE_W-1:0] pend_voice;
    logic [VC_W-1:0] vc_reg;
    logic [CNT_W-1:0] dl_reg;

    res_t result_q[$];
    note_t note_q[$];
    row_t plan[$];
    int errors;
    int results_seen;
    int stall_cnt;
    bit no_gaps;

    voice_allocator_lru_steal dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int active_voices();
        if (vc_reg == 0) return 1;
        if (vc_reg > NV) return NV;
        return int'(vc_reg);
    endfunction

    function automatic void count_up(logic [VOICE_W-1:0] v);
        if (enq_cnt[v] != CNT_MAX) enq_cnt[v] = enq_cnt[v] + 1'b1;
    endfunction

    // Advances the predicted state by one request and returns its result.
    function automatic res_t allocator_next(logic [OP_W-1:0] op, logic present,
                                            logic [VOICE_W-1:0] ev, logic samples);
        res_t r;
        int n;
        int pos;
        int k;
        logic stolen;
        logic [VOICE_W-1:0] v;
        r = '0;
        n = active_voices();
        case (op)
            OP_ALLOC: begin
                if (!present) begin
                    r.status = ST_NOT_LOADED;
                end else if (pend_vld) begin
                    r.voice = pend_voice;
                end else begin
                    pos = -1;
                    for (k = n - 1; k >= 0 && pos < 0; k--)
                        if (vmode[lru[k]] == MODE_STOPPED) pos = k;
                    stolen = (pos < 0);
                    for (k = n - 1; k >= 0 && pos < 0; k--)
                        if (vmode[lru[k]] == MODE_STOPPING) pos = k;
                    if (pos < 0) pos = n - 1;
                    v = lru[pos];
                    if (stolen) vmode[v] = MODE_STOPPED;
                    for (k = pos; k > 0; k--) lru[k] = lru[k - 1];
                    lru[0] = v;
                    pend_vld = 1'b1;
                    pend_voice = v;
                    r.voice = v;
                    r.release_stream = stolen;
                end
            end
            OP_START: begin
                if (!pend_vld) begin
                    r.status = ST_NO_PENDING;
                end else begin
                    pend_vld = 1'b0;
                    r.voice = pend_voice;
                    if (vmode[pend_voice] == MODE_STOPPED) begin
                        vmode[pend_voice] = MODE_PLAYING;
                        enq_cnt[pend_voice] = '0;
                        r.action = ACT_BUFFER;
                        r.started = 1'b1;
                    end
                end
            end
            OP_EVENT: begin
                r.voice = ev;
                if (vmode[ev] == MODE_STOPPING) begin
                    if (enq_cnt[ev] > dl_reg) begin
                        vmode[ev] = MODE_STOPPED;
                        r.action = ACT_HALT;
                    end else begin
                        count_up(ev);
                        r.action = ACT_SILENCE;
                    end
                end else if (samples) begin
                    count_up(ev);
                    r.action = ACT_BUFFER;
                end else begin
                    vmode[ev] = MODE_STOPPING;
                    r.action = ACT_SILENCE;
                    r.release_stream = 1'b1;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic res_t result_of(logic [1:0] st, logic [VOICE_W-1:0] v,
                                       logic [1:0] act, logic rel, logic stt);
        res_t r;
        r.status = st;
        r.voice = v;
        r.action = act;
        r.release_stream = rel;
        r.started = stt;
        return r;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, logic present, logic [VOICE_W-1:0] ev,
                                    logic samples, logic typed = 1'b0, res_t want = '0);
        row_t row;
        row = '{kind: ROW_REQ, op: op, present: present, ev: ev, samples: samples,
                typed: typed, want: want, idx: '0, data: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_t row;
        row = '{kind: ROW_CFG, op: '0, present: 1'b0, ev: '0, samples: 1'b0,
                typed: 1'b0, want: '0, idx: idx, data: data};
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %0s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Request, register write and result monitors share one edge so that the
    // prediction sees the configuration in the order the block does.
    always @(posedge aclk) begin : monitor
        note_t note;
        res_t pred;
        res_t got;
        res_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_VOICE_COUNT) vc_reg = cfg_data[VC_W-1:0];
                else if (cfg_index == CFG_DRAIN_LIMIT) dl_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                note = note_q.pop_front();
                pred = allocator_next(s_tuser, s_tdata[0], s_tdata[4:1], s_tdata[5]);
                result_q.push_back(note.typed ? note.want : pred);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata[$bits(res_t)-1:0];
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", int'(got), 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.voice != want.voice)
                        report_mismatch("voice", got.voice, want.voice);
                    if (got.action != want.action)
                        report_mismatch("action", got.action, want.action);
                    if (got.release_stream != want.release_stream)
                        report_mismatch("release_stream", got.release_stream,
                                        want.release_stream);
                    if (got.started != want.started)
                        report_mismatch("started", got.started, want.started);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Result sink: random back-pressure, one long hold-off to fill the block.
    initial begin : sink
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    task automatic send_req(logic [OP_W-1:0] op, logic present, logic [VOICE_W-1:0] ev,
                            logic samples, logic typed = 1'b0, res_t want = '0);
        note_q.push_back('{typed: typed, want: want});
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, samples, ev, present};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic await_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        await_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int done;
        int burst;
        int k;
        int n;
        logic [VOICE_W-1:0] v;
        done = 0;
        n = active_voices();
        while (done < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    // Allocate, start, then a burst of events to one voice.
                    send_req(OP_ALLOC, 1'b1, VOICE_W'($urandom), 1'($urandom));
                    send_req(OP_START, 1'($urandom), VOICE_W'($urandom), 1'($urandom));
                    burst = $urandom_range(8);
                    v = VOICE_W'($urandom_range(n - 1));
                    for (k = 0; k < burst; k++)
                        send_req(OP_EVENT, 1'($urandom), v,
                                 (k < burst / 2) ? ($urandom_range(3) != 0)
                                                 : ($urandom_range(3) == 0));
                    done += 2 + burst;
                end
                4: begin
                    send_req(OP_ALLOC, 1'b1, VOICE_W'($urandom), 1'($urandom));
                    done++;
                end
                5: begin
                    send_req(OP_START, 1'($urandom), VOICE_W'($urandom), 1'($urandom));
                    done++;
                end
                6: begin
                    send_req(OP_EVENT, 1'($urandom), VOICE_W'($urandom), 1'($urandom));
                    done++;
                end
                7: begin
                    send_req(OP_ALLOC, 1'b0, VOICE_W'($urandom), 1'($urandom));
                    done++;
                end
                8: begin
                    send_req(OP_W'($urandom), 1'($urandom), VOICE_W'($urandom),
                             1'($urandom));
                    done++;
                end
                default: begin
                    v = VOICE_W'($urandom_range(n - 1));
                    burst = $urandom_range(2, 6);
                    for (k = 0; k < burst; k++)
                        send_req(OP_EVENT, 1'($urandom), v, 1'b0);
                    done += burst;
                end
            endcase
            if ($urandom_range(49) == 0) await_idle();
        end
    endtask

    task automatic random_part(int total);
        int done;
        int len;
        int vc;
        int dl;
        done = 0;
        while (done < total) begin
            case ($urandom_range(7))
                0: vc = 0;
                1: vc = 1;
                2: vc = 2;
                3: vc = 3;
                4: vc = NV;
                5: vc = 31;
                default: vc = $urandom_range(1, NV);
            endcase
            case ($urandom_range(7))
                0: dl = 0;
                1: dl = 1;
                2: dl = CNT_MAX;
                3: dl = $urandom_range(CNT_MAX);
                default: dl = $urandom_range(2, 24);
            endcase
            write_reg(CFG_VOICE_COUNT, CFG_DATA_W'(vc));
            write_reg(CFG_DRAIN_LIMIT, CFG_DATA_W'(dl));
            len = $urandom_range(60, 180);
            random_phase(len);
            done += len;
        end
    endtask

    initial begin : stimulus
        int i;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        results_seen = 0;
        stall_cnt = 0;
        no_gaps = 1'b0;
        for (i = 0; i < NV; i++) begin
            lru[i] = VOICE_W'(i);
            vmode[i] = MODE_STOPPED;
            enq_cnt[i] = '0;
        end
        pend_vld = 1'b0;
        pend_voice = '0;
        vc_reg = VC_RESET;
        dl_reg = DL_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unused opcode, start with nothing pending, sound not loaded.
        add_row(OP_UNUSED, 1'b1, 4'hF, 1'b1, 1'b1,
                result_of(ST_OK, 4'd0, ACT_NONE, 1'b0, 1'b0));
        add_row(OP_START, 1'b0, 4'h0, 1'b0, 1'b1,
                result_of(ST_NO_PENDING, 4'd0, ACT_NONE, 1'b0, 1'b0));
        add_row(OP_ALLOC, 1'b0, 4'hF, 1'b1, 1'b1,
                result_of(ST_NOT_LOADED, 4'd0, ACT_NONE, 1'b0, 1'b0));
        // The oldest voice after reset is the last one; a second allocate repeats it.
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0, 1'b1,
                result_of(ST_OK, 4'd15, ACT_NONE, 1'b0, 1'b0));
        add_row(OP_ALLOC, 1'b1, 4'h5, 1'b1, 1'b1,
                result_of(ST_OK, 4'd15, ACT_NONE, 1'b0, 1'b0));
        add_row(OP_START, 1'b1, 4'hA, 1'b1, 1'b1,
                result_of(ST_OK, 4'd15, ACT_BUFFER, 1'b0, 1'b1));
        add_row(OP_EVENT, 1'b0, 4'hF, 1'b1, 1'b1,
                result_of(ST_OK, 4'd15, ACT_BUFFER, 1'b0, 1'b0));
        add_row(OP_EVENT, 1'b1, 4'hF, 1'b0, 1'b1,
                result_of(ST_OK, 4'd15, ACT_SILENCE, 1'b1, 1'b0));
        add_row(OP_EVENT, 1'b0, 4'hF, 1'b1);
        add_cfg(CFG_DRAIN_LIMIT, 16'd1);
        add_row(OP_EVENT, 1'b0, 4'hF, 1'b0);
        add_row(OP_EVENT, 1'b0, 4'h0, 1'b1);
        add_row(OP_EVENT, 1'b0, 4'h0, 1'b0);
        // One voice: a pending voice that stops before its start, then steals.
        add_cfg(CFG_VOICE_COUNT, 16'd1);
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0);
        add_row(OP_EVENT, 1'b0, 4'hF, 1'b0);
        add_row(OP_START, 1'b0, 4'h0, 1'b0);
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0);
        add_row(OP_START, 1'b0, 4'h0, 1'b0);
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0);
        add_row(OP_START, 1'b0, 4'h0, 1'b0);
        // Out-of-range voice counts clamp to one and to the maximum.
        add_cfg(CFG_VOICE_COUNT, 16'd0);
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0);
        add_row(OP_START, 1'b0, 4'h0, 1'b0);
        add_cfg(CFG_VOICE_COUNT, 16'd31);
        add_row(OP_ALLOC, 1'b1, 4'h0, 1'b0);
        add_row(OP_START, 1'b0, 4'h0, 1'b0);
        add_cfg(CFG_SPARE, 16'hFFFF);
        add_cfg(CFG_DRAIN_LIMIT, 16'd0);
        add_row(OP_EVENT, 1'b0, 4'h0, 1'b1);
        add_cfg(CFG_VOICE_COUNT, CFG_DATA_W'(NV));
        add_cfg(CFG_DRAIN_LIMIT, DL_RESET);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_req(plan[i].op, plan[i].present, plan[i].ev, plan[i].samples,
                         plan[i].typed, plan[i].want);
        end

        random_part(RANDOM_ITEMS);

        // A stretch in which neither side idles.
        no_gaps = 1'b1;
        random_phase(GAPLESS_ITEMS);
        await_idle();
        no_gaps = 1'b0;

        random_part(RANDOM_ITEMS);

        await_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vla_pkg.sv
rtl/vla_ctrl.sv
rtl/vla_dp.sv
rtl/voice_allocator_lru_steal.sv
tb/tb.sv
